FILE: hw/rtl/vertex_proximity_clusterer_unit_defines.svh
// ----------------------------------------------------------------------------
// Vertex proximity clusterer assertion macros
// Shared assertion wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef VERTEX_PROXIMITY_CLUSTERER_UNIT_DEFINES_SVH
`define VERTEX_PROXIMITY_CLUSTERER_UNIT_DEFINES_SVH

`ifndef SYNTH
`define VPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define VPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VPC_ASSERT(lbl, prop, msg)
`define VPC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: hw/rtl/vpc_pkg.sv
// ----------------------------------------------------------------------------
// Vertex proximity clusterer package
// Record types, widths and saturating adders shared by the cells and the top.
// ----------------------------------------------------------------------------
package vpc_pkg;

  localparam int POS_W  = 24;
  localparam int MOM_W  = 24;
  localparam int SUM_W  = 32;
  localparam int PT2_W  = 63;
  localparam int PSQ_W  = 48;   // px*px + py*py
  localparam int DSQ_W  = 49;   // one squared coordinate difference
  localparam int D2_W   = 51;   // sum of three squared differences
  localparam int CUT_W  = 10;
  localparam int CUT2_W = 20;

  localparam logic FUNC_ADD = 1'b0;
  localparam logic FUNC_END = 1'b1;
  localparam logic KIND_CLUSTER = 1'b0;
  localparam logic KIND_PV      = 1'b1;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
    logic signed [MOM_W-1:0] px;
    logic signed [MOM_W-1:0] py;
    logic signed [MOM_W-1:0] pz;
    logic        [MOM_W-1:0] e;
  } part_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
    logic signed [SUM_W-1:0] px;
    logic signed [SUM_W-1:0] py;
    logic signed [SUM_W-1:0] pz;
    logic        [SUM_W-1:0] e;
    logic        [PT2_W-1:0] pt2;
  } rec_t;

  function automatic logic signed [SUM_W-1:0] sat_add_s32(
    input logic signed [SUM_W-1:0] a, input logic signed [MOM_W-1:0] b);
    logic signed [SUM_W:0] s;
    s = {a[SUM_W-1], a} + {{(SUM_W-MOM_W+1){b[MOM_W-1]}}, b};
    if (s[SUM_W] != s[SUM_W-1]) begin
      sat_add_s32 = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sat_add_s32 = s[SUM_W-1:0];
    end
  endfunction

  function automatic logic [SUM_W-1:0] sat_add_u32(
    input logic [SUM_W-1:0] a, input logic [MOM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {{(SUM_W-MOM_W+1){1'b0}}, b};
    sat_add_u32 = s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

  function automatic logic [PT2_W-1:0] sat_add_u63(
    input logic [PT2_W-1:0] a, input logic [PSQ_W-1:0] b);
    logic [PT2_W:0] s;
    s = {1'b0, a} + {{(PT2_W-PSQ_W+1){1'b0}}, b};
    sat_add_u63 = s[PT2_W] ? {PT2_W{1'b1}} : s[PT2_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/vertex_proximity_clusterer_unit.sv
// Add item: ST_SQ1 and ST_SQ2 square the inputs, then the search token walks one
// cell per cycle; input is ready again once a cell consumes it or it leaves the chain.
// End item: one record per stored cluster plus the primary vertex record, one
// per cycle when the output is not stalled, as the chain shifts toward cell 0.
// Reset (rst_n, synchronous, active low) empties the table, clears the drop
// flag and sets the cutoff to 5 um.
// ----------------------------------------------------------------------------
// Vertex proximity clusterer top level
// Leader clustering of particles by production vertex over a chain of cells.
// ----------------------------------------------------------------------------
`include "vertex_proximity_clusterer_unit_defines.svh"

module vertex_proximity_clusterer_unit import vpc_pkg::*; #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [9:0]   cfg_wr_data,   // cutoff_um
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [167:0] in_tdata,      // vtx_x, vtx_y, vtx_z, mom_x, mom_y, mom_z, energy
  input  logic         in_tuser,      // func
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [263:0] out_tdata,     // pos_x, pos_y, pos_z, sum_px, sum_py, sum_pz,
                                      // sum_e, pt2_sum, overflow
  output logic         out_tuser,     // kind
  output logic         out_tlast      // last
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SQ1  = 5'b00010,
    ST_SQ2  = 5'b00100,
    ST_SRCH = 5'b01000,
    ST_RD   = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CUT_W-1:0]   cutoff_r;
  logic [CUT2_W-1:0]  cut2_r;
  part_t              part_r;
  logic [2*MOM_W-1:0] pxsq_r, pysq_r;
  logic [PSQ_W-1:0]   pt2_r;
  logic               tok_r;
  logic               drop_r;
  logic [PT2_W-1:0]   best_pt2_r;
  logic signed [POS_W-1:0] best_x_r, best_y_r, best_z_r;

  logic               out_valid_r, out_kind_r, out_last_r, out_ovf_r;
  rec_t               out_rec_r;

  logic [TABLE_DEPTH:0]   tok;
  logic [TABLE_DEPTH-1:0] consume;
  logic [TABLE_DEPTH:0]   valid_c;
  rec_t                   rec_c [TABLE_DEPTH+1];
  logic                   shift;
  logic                   pv_load;
  logic                   out_free;
  logic                   accept;
  logic signed [2*MOM_W-1:0] pxsq, pysq;

  assign accept   = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign out_free = !out_valid_r || out_tready;
  assign shift    = (state_r == ST_RD) && out_free && valid_c[0];
  assign pv_load  = (state_r == ST_RD) && out_free && !valid_c[0];

  assign pxsq = part_r.px * part_r.px;
  assign pysq = part_r.py * part_r.py;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r <= CUT_W'(5);
    end else if (cfg_wr_en) begin
      cutoff_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    cut2_r <= cutoff_r * cutoff_r;
    pxsq_r <= pxsq;
    pysq_r <= pysq;
    pt2_r  <= {1'b0, pxsq_r[PSQ_W-2:0]} + {1'b0, pysq_r[PSQ_W-2:0]};
    if (accept && in_tuser == FUNC_ADD) begin
      part_r.x  <= in_tdata[23:0];
      part_r.y  <= in_tdata[47:24];
      part_r.z  <= in_tdata[71:48];
      part_r.px <= in_tdata[95:72];
      part_r.py <= in_tdata[119:96];
      part_r.pz <= in_tdata[143:120];
      part_r.e  <= in_tdata[167:144];
    end
  end

  // The token enters cell 0; a valid, non-matching cell passes it on.
  assign tok[0]              = tok_r;
  assign valid_c[TABLE_DEPTH] = 1'b0;
  assign rec_c[TABLE_DEPTH]  = '0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    vpc_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .part_i     (part_r),
      .pt2_i      (pt2_r),
      .cut2_i     (cut2_r),
      .tok_i      (tok[i]),
      .tok_o      (tok[i+1]),
      .consume_o  (consume[i]),
      .shift_i    (shift),
      .nb_valid_i (valid_c[i+1]),
      .nb_rec_i   (rec_c[i+1]),
      .valid_o    (valid_c[i]),
      .rec_o      (rec_c[i])
    );
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_tuser == FUNC_END) ? ST_RD : ST_SQ1;
        end
      end
      ST_SQ1:  state_nxt = ST_SQ2;
      ST_SQ2:  state_nxt = ST_SRCH;
      ST_SRCH: begin
        if ((|consume) || tok[TABLE_DEPTH]) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RD: begin
        if (out_free && !valid_c[0]) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tok_r       <= 1'b0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tok_r   <= (state_r == ST_SQ2);
      if (state_r == ST_SRCH && tok[TABLE_DEPTH]) begin
        drop_r <= 1'b1;
      end
      if (state_r == ST_RD && out_free) begin
        out_valid_r <= 1'b1;
        if (!valid_c[0]) begin
          drop_r <= 1'b0;
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Records leave cell 0 in table order; the first strictly greatest pt2 wins.
  always_ff @(posedge clk) begin
    if (accept) begin
      best_pt2_r <= '0;
      best_x_r   <= '0;
      best_y_r   <= '0;
      best_z_r   <= '0;
    end else if (shift && rec_c[0].pt2 > best_pt2_r) begin
      best_pt2_r <= rec_c[0].pt2;
      best_x_r   <= rec_c[0].x;
      best_y_r   <= rec_c[0].y;
      best_z_r   <= rec_c[0].z;
    end
    if (state_r == ST_RD && out_free) begin
      out_ovf_r <= drop_r;
      if (valid_c[0]) begin
        out_rec_r  <= rec_c[0];
        out_kind_r <= KIND_CLUSTER;
        out_last_r <= 1'b0;
      end else begin
        out_rec_r.x   <= best_x_r;
        out_rec_r.y   <= best_y_r;
        out_rec_r.z   <= best_z_r;
        out_rec_r.px  <= '0;
        out_rec_r.py  <= '0;
        out_rec_r.pz  <= '0;
        out_rec_r.e   <= '0;
        out_rec_r.pt2 <= '0;
        out_kind_r    <= KIND_PV;
        out_last_r    <= 1'b1;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_ovf_r, out_rec_r.pt2, out_rec_r.e, out_rec_r.pz, out_rec_r.py,
                       out_rec_r.px, out_rec_r.z, out_rec_r.y, out_rec_r.x};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  `VPC_ASSERT(a_last_is_pv, (out_tvalid && out_tlast) |-> (out_tuser == KIND_PV), "last not PV")
  `VPC_ASSERT(a_add_busy, (accept && in_tuser == FUNC_ADD) |=> (state_r == ST_SQ1), "add idle")
  `VPC_ASSERT(a_drop_clear, pv_load |=> !drop_r, "drop flag survived the readout")
  `VPC_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_r == ST_IDLE && !out_valid_r), "not idle")

endmodule

FILE: hw/rtl/vpc_cell.sv
// ----------------------------------------------------------------------------
// Vertex proximity clusterer cell
// Holds one cluster, tests the search token against its seed and shifts its
// record toward the head of the chain during readout.
// ----------------------------------------------------------------------------
module vpc_cell import vpc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  part_t             part_i,
  input  logic [PSQ_W-1:0]  pt2_i,
  input  logic [CUT2_W-1:0] cut2_i,
  input  logic              tok_i,
  output logic              tok_o,
  output logic              consume_o,
  input  logic              shift_i,
  input  logic              nb_valid_i,
  input  rec_t              nb_rec_i,
  output logic              valid_o,
  output rec_t              rec_o
);

  logic              valid_r;
  rec_t              rec_r;
  logic              tok_r;
  logic [DSQ_W-1:0]  sqx_r, sqy_r, sqz_r;
  logic signed [POS_W:0] dx, dy, dz;
  logic signed [2*POS_W+1:0] px2, py2, pz2;
  logic [D2_W-1:0]   d2;
  logic              hit;

  assign dx = {rec_r.x[POS_W-1], rec_r.x} - {part_i.x[POS_W-1], part_i.x};
  assign dy = {rec_r.y[POS_W-1], rec_r.y} - {part_i.y[POS_W-1], part_i.y};
  assign dz = {rec_r.z[POS_W-1], rec_r.z} - {part_i.z[POS_W-1], part_i.z};
  assign px2 = dx * dx;
  assign py2 = dy * dy;
  assign pz2 = dz * dz;

  // Squares are refreshed every cycle; the particle holds still during a search.
  always_ff @(posedge clk) begin
    sqx_r <= px2[DSQ_W-1:0];
    sqy_r <= py2[DSQ_W-1:0];
    sqz_r <= pz2[DSQ_W-1:0];
  end

  assign d2 = {2'b00, sqx_r} + {2'b00, sqy_r} + {2'b00, sqz_r};
  assign hit = d2 < {{(D2_W-CUT2_W){1'b0}}, cut2_i};
  assign consume_o = tok_i && (!valid_r || hit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= 1'b0;
    end else begin
      tok_r <= tok_i && valid_r && !hit;
      if (shift_i) begin
        valid_r <= nb_valid_i;
      end else if (tok_i && !valid_r) begin
        valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift_i) begin
      rec_r <= nb_rec_i;
    end else if (tok_i && !valid_r) begin
      rec_r.x   <= part_i.x;
      rec_r.y   <= part_i.y;
      rec_r.z   <= part_i.z;
      rec_r.px  <= SUM_W'(part_i.px);
      rec_r.py  <= SUM_W'(part_i.py);
      rec_r.pz  <= SUM_W'(part_i.pz);
      rec_r.e   <= {{(SUM_W-MOM_W){1'b0}}, part_i.e};
      rec_r.pt2 <= {{(PT2_W-PSQ_W){1'b0}}, pt2_i};
    end else if (tok_i && hit) begin
      rec_r.px  <= sat_add_s32(rec_r.px, part_i.px);
      rec_r.py  <= sat_add_s32(rec_r.py, part_i.py);
      rec_r.pz  <= sat_add_s32(rec_r.pz, part_i.pz);
      rec_r.e   <= sat_add_u32(rec_r.e, part_i.e);
      rec_r.pt2 <= sat_add_u63(rec_r.pt2, pt2_i);
    end
  end

  assign tok_o   = tok_r;
  assign valid_o = valid_r;
  assign rec_o   = rec_r;

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Vertex proximity clusterer testbench
// Drives particles and end-of-event items into the clusterer, predicts every
// readout record with an independent behavioral table model, and compares the
// records field by field under random idling and a long output hold-off.
// ----------------------------------------------------------------------------
module tb;
  import vpc_pkg::*;

  localparam int DEPTH = 32;

  typedef struct packed {
    logic                    kind;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
    logic signed [SUM_W-1:0] px;
    logic signed [SUM_W-1:0] py;
    logic signed [SUM_W-1:0] pz;
    logic        [SUM_W-1:0] e;
    logic        [PT2_W-1:0] pt2;
    logic                    ovf;
    logic                    lst;
  } vtx_rec_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_wr_en = 1'b0;
  logic [9:0]   cfg_wr_data = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [167:0] in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [263:0] out_tdata;
  logic         out_tuser;
  logic         out_tlast;

  // Cluster table as the testbench sees it.
  logic [9:0]  cut_um;
  bit          cl_valid [DEPTH];
  longint      cl_x [DEPTH], cl_y [DEPTH], cl_z [DEPTH];
  longint      cl_px [DEPTH], cl_py [DEPTH], cl_pz [DEPTH];
  longint unsigned cl_e [DEPTH], cl_pt2 [DEPTH];
  bit          dropped;

  vtx_rec_t    pending_recs [$];
  int          err_cnt = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_cycles = 0;

  vertex_proximity_clusterer_unit #(.TABLE_DEPTH(DEPTH)) u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always #5 clk = ~clk;

  function automatic longint clamp_s32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned abs_sq(longint d);
    longint unsigned a;
    a = (d < 0) ? -d : d;
    return a * a;
  endfunction

  function automatic vtx_rec_t make_rec(bit kind, longint x, longint y, longint z,
                                        longint px, longint py, longint pz,
                                        longint unsigned e, longint unsigned pt2,
                                        bit lst);
    vtx_rec_t r;
    r.kind = kind;
    r.x = x[23:0]; r.y = y[23:0]; r.z = z[23:0];
    r.px = px[31:0]; r.py = py[31:0]; r.pz = pz[31:0];
    r.e = e[31:0]; r.pt2 = pt2[62:0];
    r.ovf = dropped; r.lst = lst;
    return r;
  endfunction

  task automatic enqueue_rec(vtx_rec_t r);
    pending_recs = {pending_recs, r};
  endtask

  // Applies one accepted item to the table model and queues any readout.
  task automatic cluster_predict(logic fn, part_t p);
    longint x, y, z, px, py, pz;
    longint unsigned e, pt2, cut2, d2, best_pt2;
    int hit, free_slot, best;
    if (fn == FUNC_ADD) begin
      x = longint'(p.x); y = longint'(p.y); z = longint'(p.z);
      px = longint'(p.px); py = longint'(p.py); pz = longint'(p.pz);
      e = longint'(p.e);
      pt2 = abs_sq(px) + abs_sq(py);
      cut2 = longint'(cut_um) * longint'(cut_um);
      hit = -1; free_slot = -1;
      for (int i = 0; i < DEPTH; i++) begin
        if (cl_valid[i]) begin
          d2 = abs_sq(cl_x[i] - x) + abs_sq(cl_y[i] - y) + abs_sq(cl_z[i] - z);
          if (d2 < cut2) begin
            hit = i;
            break;
          end
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      if (hit >= 0) begin
        cl_px[hit] = clamp_s32(cl_px[hit] + px);
        cl_py[hit] = clamp_s32(cl_py[hit] + py);
        cl_pz[hit] = clamp_s32(cl_pz[hit] + pz);
        cl_e[hit] = (cl_e[hit] + e > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : cl_e[hit] + e;
        cl_pt2[hit] = (cl_pt2[hit] > 64'h7FFF_FFFF_FFFF_FFFF - pt2) ?
                      64'h7FFF_FFFF_FFFF_FFFF : cl_pt2[hit] + pt2;
      end else if (free_slot >= 0) begin
        cl_valid[free_slot] = 1'b1;
        cl_x[free_slot] = x; cl_y[free_slot] = y; cl_z[free_slot] = z;
        cl_px[free_slot] = px; cl_py[free_slot] = py; cl_pz[free_slot] = pz;
        cl_e[free_slot] = e; cl_pt2[free_slot] = pt2;
      end else begin
        dropped = 1'b1;
      end
    end else begin
      best = -1; best_pt2 = 0;
      for (int i = 0; i < DEPTH; i++) begin
        if (cl_valid[i]) begin
          enqueue_rec(make_rec(KIND_CLUSTER, cl_x[i], cl_y[i], cl_z[i],
                               cl_px[i], cl_py[i], cl_pz[i], cl_e[i],
                               cl_pt2[i], 1'b0));
          if (cl_pt2[i] > best_pt2) begin
            best_pt2 = cl_pt2[i];
            best = i;
          end
        end
      end
      if (best >= 0)
        enqueue_rec(make_rec(KIND_PV, cl_x[best], cl_y[best], cl_z[best],
                             0, 0, 0, 0, 0, 1'b1));
      else
        enqueue_rec(make_rec(KIND_PV, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
      for (int i = 0; i < DEPTH; i++) cl_valid[i] = 1'b0;
      dropped = 1'b0;
    end
  endtask

  // The item stays offered after acceptance until the next one replaces it or
  // the sender idles, so back-to-back items need no gap.
  task automatic send_item(logic fn, part_t p);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= {p.e, p.pz, p.py, p.px, p.z, p.y, p.x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    cluster_predict(fn, p);
  endtask

  function automatic part_t mk_part(int x, int y, int z, int px, int py, int pz, int e);
    part_t p;
    p.x = x[23:0]; p.y = y[23:0]; p.z = z[23:0];
    p.px = px[23:0]; p.py = py[23:0]; p.pz = pz[23:0]; p.e = e[23:0];
    return p;
  endfunction

  function automatic part_t rand_part();
    return mk_part($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  // Positions near a few event centers so that particles actually merge.
  function automatic part_t near_part(int cx, int spread);
    part_t p;
    p = rand_part();
    p.x = 24'(cx + $urandom_range(2 * spread) - spread);
    p.y = 24'($urandom_range(2 * spread) - spread);
    p.z = 24'(-cx + $urandom_range(2 * spread) - spread);
    if ($urandom_range(3) != 0) begin
      p.px = 24'($urandom_range(4000) - 2000);
      p.py = 24'($urandom_range(4000) - 2000);
      p.pz = 24'($urandom_range(4000) - 2000);
      p.e  = 24'($urandom_range(8000));
    end
    return p;
  endfunction

  task automatic end_event();
    send_item(FUNC_END, '0);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_recs.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
  endtask

  task automatic write_cutoff(logic [9:0] v);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cut_um = v;
  endtask

  task automatic test_directed();
    // Empty event gives only the primary vertex at the origin.
    end_event();
    // Extremes of every field, exact boundary of the cutoff at the reset value.
    send_item(FUNC_ADD, mk_part(0, 0, 0, 1, 2, 3, 4));
    send_item(FUNC_ADD, mk_part(4, 0, 0, -5, 6, -7, 8));
    send_item(FUNC_ADD, mk_part(5, 0, 0, 9, 9, 9, 9));
    send_item(FUNC_ADD, mk_part(3, 3, 3, 1, 1, 1, 1));
    send_item(FUNC_ADD, mk_part(-8388608, -8388608, -8388608,
                                -8388608, -8388608, -8388608, 16777215));
    send_item(FUNC_ADD, mk_part(8388607, 8388607, 8388607,
                                8388607, 8388607, 8388607, 16777215));
    end_event();
    // Momentum sums clamp high and low, and the energy sum clamps, on one cluster.
    for (int i = 0; i < 260; i++)
      send_item(FUNC_ADD, mk_part(100, 100, 100, 8388607, -8388608, 8388607, 16777215));
    end_event();
  endtask

  task automatic test_overflow();
    // More distinct vertices than the table holds, with pt2 ties.
    for (int i = 0; i < DEPTH + 4; i++)
      send_item(FUNC_ADD, mk_part(i * 1000, 0, 0, 3, 4, 0, 1));
    end_event();
    end_event();
  endtask

  task automatic test_cutoffs();
    logic [9:0] cuts [4] = '{10'd0, 10'd1023, 10'd1, 10'd37};
    foreach (cuts[k]) begin
      write_cutoff(cuts[k]);
      for (int i = 0; i < 5; i++) send_item(FUNC_ADD, near_part(0, 600));
      send_item(FUNC_ADD, mk_part(0, 0, 0, 0, 0, 0, 0));
      end_event();
    end
  endtask

  task automatic test_random(int n_items);
    int sent;
    int n_ev;
    sent = 0;
    while (sent < n_items) begin
      n_ev = $urandom_range(40);
      for (int i = 0; i < n_ev; i++) begin
        case ($urandom_range(9))
          0, 1:    send_item(FUNC_ADD, rand_part());
          default: send_item(FUNC_ADD, near_part(($urandom_range(3) - 1) * 5000,
                                                 $urandom_range(2, 80)));
        endcase
      end
      end_event();
      sent += n_ev + 1;
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    for (int i = 0; i < 30; i++) send_item(FUNC_ADD, near_part(0, 40));
    end_event();
    for (int i = 0; i < 10; i++) send_item(FUNC_ADD, near_part(2000, 40));
    end_event();
    wait_drained();
  endtask

  task automatic set_idling(int s, int r);
    send_idle_pct = s;
    recv_stall_pct = r;
  endtask

  // Receiver: random stalls, plus an optional long hold-off.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready  <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    vtx_rec_t got, exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind = out_tuser;
      got.lst  = out_tlast;
      {got.ovf, got.pt2, got.e, got.pz, got.py, got.px, got.z, got.y, got.x} =
        out_tdata;
      if (pending_recs.size() == 0) begin
        $error("record with nothing expected: kind=%0d", got.kind);
        err_cnt++;
      end else begin
        exp_r = pending_recs.pop_front();
        if (got.kind !== exp_r.kind) begin
          $error("kind exp %0d got %0d", exp_r.kind, got.kind); err_cnt++;
        end
        if (got.x !== exp_r.x) begin
          $error("pos_x exp %0d got %0d", exp_r.x, got.x); err_cnt++;
        end
        if (got.y !== exp_r.y) begin
          $error("pos_y exp %0d got %0d", exp_r.y, got.y); err_cnt++;
        end
        if (got.z !== exp_r.z) begin
          $error("pos_z exp %0d got %0d", exp_r.z, got.z); err_cnt++;
        end
        if (got.px !== exp_r.px) begin
          $error("sum_px exp %0d got %0d", exp_r.px, got.px); err_cnt++;
        end
        if (got.py !== exp_r.py) begin
          $error("sum_py exp %0d got %0d", exp_r.py, got.py); err_cnt++;
        end
        if (got.pz !== exp_r.pz) begin
          $error("sum_pz exp %0d got %0d", exp_r.pz, got.pz); err_cnt++;
        end
        if (got.e !== exp_r.e) begin
          $error("sum_e exp %0d got %0d", exp_r.e, got.e); err_cnt++;
        end
        if (got.pt2 !== exp_r.pt2) begin
          $error("pt2_sum exp %0d got %0d", exp_r.pt2, got.pt2); err_cnt++;
        end
        if (got.ovf !== exp_r.ovf) begin
          $error("overflow exp %0d got %0d", exp_r.ovf, got.ovf); err_cnt++;
        end
        if (got.lst !== exp_r.lst) begin
          $error("last exp %0d got %0d", exp_r.lst, got.lst); err_cnt++;
        end
      end
    end
  end

  initial begin
    #20000000;
    $display("status: fail");
    $finish;
  end

  initial begin
    cut_um = 10'd5;
    dropped = 1'b0;
    foreach (cl_valid[i]) cl_valid[i] = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_idling(0, 0);
    test_directed();
    test_overflow();
    test_cutoffs();
    write_cutoff(10'd60);
    set_idling(0, 0);
    test_random(20);
    set_idling(56, 0);
    test_random(20);
    set_idling(0, 56);
    test_random(20);
    set_idling(33, 33);
    test_random(20);
    set_idling(0, 0);
    test_backpressure();
    write_cutoff(10'd5);
    test_random(10);
    wait_drained();
    if (err_cnt == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/vpc_pkg.sv
hw/rtl/vpc_cell.sv
hw/rtl/vertex_proximity_clusterer_unit.sv
tb/sv/tb.sv
